/* rtl/mmq_pkg.sv */
// ----------------------------------------------------------------------------
// mmq_pkg
// Types and codes used by the mailbox message queue, including its memory word.
// ----------------------------------------------------------------------------
package mmq_pkg;

    localparam logic [2:0] ACT_CREATE  = 3'd0;
    localparam logic [2:0] ACT_DESTROY = 3'd1;
    localparam logic [2:0] ACT_FIND    = 3'd2;
    localparam logic [2:0] ACT_SEND    = 3'd3;
    localparam logic [2:0] ACT_RECEIVE = 3'd4;
    localparam logic [2:0] ACT_COUNT   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PARAM    = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_NOSLOT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] box_id;
        logic [63:0] name_key;
        logic [63:0] payload;
        logic [15:0] msg_size;
        logic [15:0] rx_limit;
        logic [15:0] sender_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] id_out;
        logic [63:0] payload_out;
        logic [3:0]  size_out;
        logic [15:0] sender_out;
        logic [4:0]  count_out;
    } t_out_item;

    // Message memory word: data, byte count, sender.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  size;
        logic [15:0] sender;
    } t_msg;

    // Mask that keeps the lowest n bytes of a 64-bit word.
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* rtl/mmq_ram.sv */
// ----------------------------------------------------------------------------
// mmq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mmq_ram #(
    parameter int WIDTH = 84,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/multi_mailbox_message_queue.sv */
// ----------------------------------------------------------------------------
// multi_mailbox_message_queue
// Table of named mailboxes, each a ring of messages held in one memory.
// ----------------------------------------------------------------------------
// An item is taken in the idle state and executed in the next cycle, so the
// block takes no new item while one is in execution; its result is registered
// when execution ends. A successful receive passes through a read state as well,
// because the message memory has a registered read port. The block accepts
// one item at a time but takes the next while a finished result is still
// waiting to be collected; that next item then waits in execution until the
// output register is free.
// The mailbox table itself is held in flip-flops and matched in parallel;
// the message memory needs no clearing after reset, as it is only read at
// positions written since the mailbox was created.
module multi_mailbox_message_queue
    import mmq_pkg::*;
#(
    parameter int NUM_BOXES  = 8,
    parameter int CAPACITY   = 16,
    parameter int MSG_BYTES  = 8,
    parameter int NAME_BYTES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int SW    = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int CW    = $clog2(CAPACITY);
    localparam int OW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = NUM_BOXES * CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $bits(t_msg);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ} t_state;

    t_state    r_state;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic [31:0] r_next_id;

    logic          r_active [NUM_BOXES];
    logic [31:0]   r_id     [NUM_BOXES];
    logic [63:0]   r_name   [NUM_BOXES];
    logic [CW-1:0] r_rd_idx [NUM_BOXES];
    logic [CW-1:0] r_wr_idx [NUM_BOXES];
    logic [OW-1:0] r_occ    [NUM_BOXES];

    logic [63:0]   nm;
    logic          id_found, name_found, free_found;
    logic [SW-1:0] id_slot, free_slot, name_slot;
    logic          out_free;
    logic          out_done;
    logic          n_out_valid;
    t_out_item     n_out;
    logic [3:0]    clamp_size;
    logic [3:0]    rx_size;
    logic [OW-1:0] sel_occ;
    logic [CW-1:0] sel_rd, sel_wr;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_msg          ram_wdata, ram_rdata;
    logic [2:0]    exec_status;
    logic          rx_go;

    // Name cut at its first zero byte and limited to the configured length.
    always_comb begin
        logic stop;
        nm   = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= NAME_BYTES || r_in.name_key[8*i +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                nm[8*i +: 8] = r_in.name_key[8*i +: 8];
            end
        end
    end

    always_comb begin
        id_found   = 1'b0;
        id_slot    = '0;
        name_found = 1'b0;
        name_slot  = '0;
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_BOXES - 1; i >= 0; i--) begin
            if (r_active[i] && r_id[i] == r_in.box_id) begin
                id_found = 1'b1;
                id_slot  = SW'(i);
            end
            if (r_active[i] && r_name[i] == nm) begin
                name_found = 1'b1;
                name_slot  = SW'(i);
            end
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    always_comb begin
        sel_occ = r_occ[id_slot];
        sel_rd  = r_rd_idx[id_slot];
        sel_wr  = r_wr_idx[id_slot];
        if (r_in.msg_size > 16'(MSG_BYTES)) begin
            clamp_size = 4'(MSG_BYTES);
        end else begin
            clamp_size = r_in.msg_size[3:0];
        end
    end

    // Status of the item under execution, with the checks for each action in priority order.
    always_comb begin
        exec_status = ST_OK;
        unique case (r_in.action)
            ACT_CREATE: begin
                if (nm == '0) exec_status = ST_PARAM;
                else if (name_found) exec_status = ST_EXISTS;
                else if (!free_found) exec_status = ST_NOSLOT;
            end
            ACT_DESTROY, ACT_COUNT: begin
                if (!id_found) exec_status = ST_NOTFOUND;
            end
            ACT_FIND: begin
                if (!name_found || nm == '0) exec_status = ST_NOTFOUND;
            end
            ACT_SEND: begin
                if (!id_found) exec_status = ST_NOTFOUND;
                else if (r_in.msg_size == '0) exec_status = ST_PARAM;
                else if (sel_occ >= OW'(CAPACITY)) exec_status = ST_FULL;
            end
            ACT_RECEIVE: begin
                if (!id_found) exec_status = ST_NOTFOUND;
                else if (r_in.rx_limit == '0) exec_status = ST_PARAM;
                else if (sel_occ == '0) exec_status = ST_EMPTY;
            end
            default: exec_status = ST_PARAM;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign rx_go    = (r_state == S_EXEC) && (r_in.action == ACT_RECEIVE)
                      && (exec_status == ST_OK);
    assign out_done = ((r_state == S_EXEC) && !rx_go && out_free)
                      || ((r_state == S_READ) && out_free);
    assign n_out_valid = out_done ? 1'b1 : (r_out_valid && i_out_stall);

    assign ram_we           = (r_state == S_EXEC) && out_free
                              && (r_in.action == ACT_SEND) && (exec_status == ST_OK);
    assign ram_waddr        = AW'(id_slot * CAPACITY + sel_wr);
    assign ram_wdata.data   = r_in.payload & byte_mask(clamp_size);
    assign ram_wdata.size   = clamp_size;
    assign ram_wdata.sender = r_in.sender_id;
    assign ram_re           = rx_go;
    assign ram_raddr        = AW'(id_slot * CAPACITY + sel_rd);

    assign rx_size = (16'(ram_rdata.size) > r_in.rx_limit) ? r_in.rx_limit[3:0]
                                                          : ram_rdata.size;

    mmq_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result of the item that completes in this cycle.
    always_comb begin
        n_out = '0;
        if (r_state == S_READ) begin
            n_out.status      = ST_OK;
            n_out.size_out    = rx_size;
            n_out.payload_out = ram_rdata.data & byte_mask(rx_size);
            n_out.sender_out  = ram_rdata.sender;
        end else begin
            n_out.status = exec_status;
            if (exec_status == ST_OK) begin
                unique case (r_in.action)
                    ACT_CREATE: n_out.id_out    = r_next_id;
                    ACT_FIND:   n_out.id_out    = r_id[name_slot];
                    ACT_COUNT:  n_out.count_out = 5'(sel_occ);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in        <= '0;
            r_out_valid <= 1'b0;
            r_next_id   <= 32'd1;
            for (int i = 0; i < NUM_BOXES; i++) begin
                r_active[i] <= 1'b0;
                r_id[i]     <= '0;
                r_name[i]   <= '0;
                r_rd_idx[i] <= '0;
                r_wr_idx[i] <= '0;
                r_occ[i]    <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (out_done) begin
                r_out <= n_out;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (rx_go) begin
                        // The ring pointer moves now; the data arrives next cycle.
                        r_rd_idx[id_slot] <= (sel_rd == CW'(CAPACITY - 1)) ? '0
                                                                            : sel_rd + 1'b1;
                        r_occ[id_slot]    <= sel_occ - 1'b1;
                        r_state           <= S_READ;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                        if (exec_status == ST_OK) begin
                            unique case (r_in.action)
                                ACT_CREATE: begin
                                    r_active[free_slot] <= 1'b1;
                                    r_id[free_slot]     <= r_next_id;
                                    r_name[free_slot]   <= nm;
                                    r_rd_idx[free_slot] <= '0;
                                    r_wr_idx[free_slot] <= '0;
                                    r_occ[free_slot]    <= '0;
                                    r_next_id           <= r_next_id + 32'd1;
                                end
                                ACT_DESTROY: begin
                                    r_active[id_slot] <= 1'b0;
                                    r_id[id_slot]     <= '0;
                                    r_name[id_slot]   <= '0;
                                end
                                ACT_SEND: begin
                                    r_wr_idx[id_slot] <=
                                        (sel_wr == CW'(CAPACITY - 1)) ? '0 : sel_wr + 1'b1;
                                    r_occ[id_slot]    <= sel_occ + 1'b1;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_read_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_READ))
        else $error("read state entered without execution");

    a_fail_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
            (r_out.payload_out == '0 && r_out.size_out == '0 && r_out.id_out == '0))
        else $error("failed item carries data");

    a_send_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_out_valid && r_out.status == ST_OK && r_state == S_IDLE))
        else $error("send wrote memory without an ok result");

endmodule
